FILE: rtl/core/slk_pkg.sv
// ----------------------------------------------------------------------------
// slk_pkg: shared types for the sorted key list
// Request and status codes, controller states and the cell command bundle.
// ----------------------------------------------------------------------------
package slk_pkg;

    localparam int KEY_W    = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 3;
    localparam int REQ_W    = 2;
    localparam int PADDR_W  = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_DUMP   = 2'd3
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_REMOVED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_DUPLICATE = 3'd4,
        ST_FULL      = 3'd5,
        ST_DUMP_ITEM = 3'd6,
        ST_EMPTY     = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC,
        S_DUMP
    } state_t;

    // what every cell does in a cycle
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CMP,
        CELL_INS,
        CELL_DEL,
        CELL_SH_DN,
        CELL_SH_UP
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic signed [KEY_W-1:0]  key;
    } cell_cmd_t;

endpackage

FILE: rtl/core/slk_cell.sv
// ----------------------------------------------------------------------------
// slk_cell: one slot of the sorted key chain
// Holds a key, compares it with the broadcast key and shifts to or from its
// neighbours on insert, remove and dump rotation.
// ----------------------------------------------------------------------------
module slk_cell
    import slk_pkg::*;
(
    input  logic                    aclk,
    input  cell_cmd_t               cmd,
    input  logic                    occupied,
    input  logic signed [KEY_W-1:0] prev_key,
    input  logic                    prev_lt,
    input  logic signed [KEY_W-1:0] next_key,
    output logic signed [KEY_W-1:0] key_q,
    output logic                    lt_q,
    output logic                    eq_q
);

    logic signed [KEY_W-1:0] key_reg, key_next;
    logic                    lt_reg, lt_next;
    logic                    eq_reg, eq_next;

    // next key and compare flags
    always_comb begin
        key_next = key_reg;
        lt_next  = lt_reg;
        eq_next  = eq_reg;
        case (cmd.op)
            CELL_CMP: begin
                lt_next = occupied && (key_reg < cmd.key);
                eq_next = occupied && (key_reg == cmd.key);
            end
            CELL_INS: begin
                // first cell not below the new key takes it, the rest move up
                if (!lt_reg) begin
                    key_next = prev_lt ? cmd.key : prev_key;
                end
            end
            CELL_DEL: begin
                if (!lt_reg) begin
                    key_next = next_key;
                end
            end
            CELL_SH_DN: key_next = next_key;
            CELL_SH_UP: key_next = prev_key;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        lt_reg  <= lt_next;
        eq_reg  <= eq_next;
    end

    assign key_q = key_reg;
    assign lt_q  = lt_reg;
    assign eq_q  = eq_reg;

endmodule

FILE: rtl/core/sorted_key_list_core.sv
// ----------------------------------------------------------------------------
// sorted_key_list_core: sorted list of distinct signed keys in a cell chain
// Insert, remove and search: taken in idle, compared in the compare state, then
// shifted and registered as a result in execute; the next request waits for idle.
// A dump emits one key per cycle in the dump state (one result for an empty
// list); output back-pressure stalls the dump and execute states.
// Synchronous active-low reset empties the list and sets ascending order.
// ----------------------------------------------------------------------------
module sorted_key_list_core
    import slk_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input transactions
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,   // [31:0] key
    input  logic [1:0]         s_tuser,   // [1:0] req_type
    // result transactions
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [39:0]        m_tdata,   // [5:0] position, [37:6] value, zero pad
    output logic [2:0]         m_tuser,   // [2:0] status
    output logic               m_tlast,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    // configuration register
    logic asc_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, asc_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            asc_reg <= 1'b1;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            asc_reg <= pwdata[0];
        end
    end

    // control and request registers
    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           dump_idx_reg, dump_idx_next;
    req_type_t               req_reg;
    logic signed [KEY_W-1:0] key_reg;

    // output register
    logic                    out_valid_reg, out_valid_next;
    status_t                 out_status_reg, out_status_next;
    logic [POS_W-1:0]        out_pos_reg, out_pos_next;
    logic signed [KEY_W-1:0] out_value_reg, out_value_next;
    logic                    out_last_reg, out_last_next;

    // cell chain signals
    cell_cmd_t               cmd;
    logic signed [KEY_W-1:0] key_vec [CAPACITY];
    logic [CAPACITY-1:0]     lt_vec;
    logic [CAPACITY-1:0]     eq_vec;
    logic [CAPACITY-1:0]     occ_vec;
    logic [CAPACITY-1:0]     last_occ;
    logic signed [KEY_W-1:0] tail_key;
    logic [IW-1:0]           found_idx;
    logic                    found;
    logic                    out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign found    = |eq_vec;

    // occupancy, last occupied cell and its key, index of the matching cell
    always_comb begin
        tail_key  = '0;
        found_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            occ_vec[i] = (CW'(i) < count_reg);
        end
        for (int i = 0; i < CAPACITY; i++) begin
            if (i == CAPACITY - 1) begin
                last_occ[i] = occ_vec[i];
            end else begin
                last_occ[i] = occ_vec[i] && !occ_vec[i+1];
            end
        end
        for (int i = 0; i < CAPACITY; i++) begin
            if (last_occ[i]) begin
                tail_key = tail_key | key_vec[i];
            end
            if (eq_vec[i]) begin
                found_idx = found_idx | IW'(i);
            end
        end
    end

    // the chain; ends wrap round the occupied region for dump rotation
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [KEY_W-1:0] prev_k;
        logic                    prev_l;
        logic signed [KEY_W-1:0] next_k;

        if (g == 0) begin : g_head
            assign prev_k = tail_key;
            assign prev_l = 1'b1;
        end else begin : g_body
            assign prev_k = key_vec[g-1];
            assign prev_l = lt_vec[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign next_k = key_vec[0];
        end else begin : g_inner
            assign next_k = last_occ[g] ? key_vec[0] : key_vec[g+1];
        end

        slk_cell u_cell (
            .aclk     (aclk),
            .cmd      (cmd),
            .occupied (occ_vec[g]),
            .prev_key (prev_k),
            .prev_lt  (prev_l),
            .next_key (next_k),
            .key_q    (key_vec[g]),
            .lt_q     (lt_vec[g]),
            .eq_q     (eq_vec[g])
        );
    end

    // next state, cell command and result
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        dump_idx_next   = dump_idx_reg;
        cmd.op          = CELL_HOLD;
        cmd.key         = key_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next    = (req_type_t'(s_tuser) == REQ_DUMP) ? S_DUMP : S_CMP;
                    dump_idx_next = '0;
                end
            end
            S_CMP: begin
                cmd.op     = CELL_CMP;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_pos_next    = '0;
                    out_value_next  = key_reg;
                    out_last_next   = 1'b1;
                    out_status_next = ST_NOT_FOUND;
                    state_next      = S_IDLE;
                    case (req_reg)
                        REQ_INSERT: begin
                            if (found) begin
                                out_status_next = ST_DUPLICATE;
                            end else if (count_reg == CW'(CAPACITY)) begin
                                out_status_next = ST_FULL;
                            end else begin
                                cmd.op          = CELL_INS;
                                count_next      = count_reg + CW'(1);
                                out_status_next = ST_INSERTED;
                            end
                        end
                        REQ_REMOVE: begin
                            if (found) begin
                                cmd.op          = CELL_DEL;
                                count_next      = count_reg - CW'(1);
                                out_status_next = ST_REMOVED;
                            end
                        end
                        REQ_SEARCH: begin
                            if (found) begin
                                out_status_next = ST_FOUND;
                                out_pos_next    = asc_reg
                                    ? POS_W'(CW'(found_idx) + CW'(1))
                                    : POS_W'(count_reg - CW'(found_idx));
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    if (count_reg == '0) begin
                        out_status_next = ST_EMPTY;
                        out_pos_next    = '0;
                        out_value_next  = '0;
                        out_last_next   = 1'b1;
                        state_next      = S_IDLE;
                    end else begin
                        // emit the head (or tail) and rotate it round
                        out_status_next = ST_DUMP_ITEM;
                        out_pos_next    = POS_W'(dump_idx_reg + CW'(1));
                        out_value_next  = asc_reg ? key_vec[0] : tail_key;
                        out_last_next   = (dump_idx_reg + CW'(1) == count_reg);
                        cmd.op          = asc_reg ? CELL_SH_DN : CELL_SH_UP;
                        dump_idx_next   = dump_idx_reg + CW'(1);
                        if (dump_idx_reg + CW'(1) == count_reg) begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_idx_reg  <= dump_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg <= req_type_t'(s_tuser);
            key_reg <= s_tdata;
        end
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_value_reg, out_pos_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_count_moves_in_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == S_EXEC))
        else $error("entry count changed outside execute");

    a_lt_thermometer: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC) |-> ((lt_vec & (lt_vec + CAPACITY'(1))) == '0))
        else $error("compare flags not in sorted order");

    a_eq_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC) |-> $onehot0(eq_vec))
        else $error("more than one matching cell");

endmodule
